>>> rtl/ppu_pkg.sv
// shared types and constants for the particle pool
`timescale 1ns / 1ps
package ppu_pkg;
  localparam int unsigned SlotCountDefault = 64;
  localparam logic [15:0] DragReset = 16'd64225;

  typedef enum logic [1:0] {
    OP_SPAWN  = 2'd0,
    OP_TICK   = 2'd1,
    OP_RENDER = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_SPAWNED = 3'd0,
    KIND_DROPPED = 3'd1,
    KIND_TICKED  = 3'd2,
    KIND_RECT    = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_e;

  // one slot as held in the slot memory
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [19:0] life;
    logic [19:0] full_life;
    logic [39:0] look;
  } slot_t;

  // one result item
  typedef struct packed {
    kind_e kind;
    logic [6:0] live;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [7:0] size;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic last;
  } res_t;
endpackage

>>> rtl/ppu_div.sv
// restoring divider for the fade ratio, one quotient bit per cycle
`timescale 1ns / 1ps
module ppu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [27:0] num_i,
  input  logic [19:0] den_i,
  output logic        done_o,
  output logic [7:0]  quot_o
);
  logic [27:0] num_q, num_d;
  logic [20:0] rem_q, rem_d;
  logic [19:0] den_q, den_d;
  logic [27:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [20:0] sh;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    sh = {rem_q[19:0], num_q[27]};
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0; quo_d = '0;
      cnt_d = 5'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[26:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[26:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[26:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd27) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = (den_q == '0) ? 8'd0 : ((|quo_q[27:8]) ? 8'hFF : quo_q[7:0]);
endmodule

>>> rtl/particle_pool_update.sv
// particle pool: spawn, tick and render over a slot memory
// spawn stops at the first free slot and reports a drop when the pool is full
// tick walks every slot, and render walks every slot to the final result
// throughput: one request at a time, the next taken the cycle after the last result is taken
// one result is held in an output register; the slot walk and the fade divider set the time
// reset clears the active flags and live count and loads the drag factor with DragReset; slot memory is not cleared
`timescale 1ns / 1ps
module particle_pool_update #(
  parameter int unsigned SlotCount = ppu_pkg::SlotCountDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0]  operation_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic [19:0] lifetime_i,
  input  logic [7:0]  dot_size_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  opacity_i,
  input  logic [15:0] time_step_i,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0]  result_kind_o,
  output logic [6:0]  live_total_o,
  output logic signed [15:0] rect_x_o,
  output logic signed [15:0] rect_y_o,
  output logic [7:0]  rect_size_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic        last_o
);
  localparam int unsigned IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CntW = $clog2(SlotCount + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SCAN  = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_MUL1  = 11'b00000001000,
    S_MUL2  = 11'b00000010000,
    S_WB    = 11'b00000100000,
    S_DIV1  = 11'b00001000000,
    S_DIV2  = 11'b00010000000,
    S_EMIT  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_NEXT  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  ppu_pkg::slot_t mem [SlotCount];
  ppu_pkg::slot_t rd_q, wr_data;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic wr_en;

  logic [SlotCount-1:0] act_q, act_d;
  logic [6:0] live_q, live_d;
  logic [15:0] drag_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [1:0] op_q, op_d;
  logic [15:0] dt_q, dt_d;
  logic any_q, any_d;
  ppu_pkg::slot_t sp_q, sp_d;
  ppu_pkg::res_t res_q, res_d;
  logic ov_q, ov_d;

  // products for the motion and drag step
  logic signed [48:0] px_q, py_q, dx_q, dy_q;
  logic [7:0] fs_q, fa_q;
  logic div_start, div_done;
  logic [27:0] div_num;
  logic [7:0] div_quot;
  logic sel_alpha_q, sel_alpha_d;
  logic [7:0] fade_x;

  assign rd_addr = idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  ppu_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(rd_q.full_life), .done_o(div_done), .quot_o(div_quot)
  );

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -34'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [15:0] corner(input logic signed [31:0] p,
                                                input logic [7:0] sz);
    logic signed [32:0] d;
    logic signed [16:0] t;
    d = {p[31], p} - $signed({10'b0, sz[7:1], 16'h0});
    // truncate toward zero
    if (d[32] && (|d[15:0])) t = d[32:16] + 17'sd1;
    else t = d[32:16];
    if (t > 17'sd32767) return 16'sh7FFF;
    else if (t < -17'sd32768) return 16'sh8000;
    else return t[15:0];
  endfunction

  logic signed [33:0] nx, ny;
  assign nx = {{2{rd_q.pos_x[31]}}, rd_q.pos_x} + {{1{px_q[48]}}, px_q[48:16]};
  assign ny = {{2{rd_q.pos_y[31]}}, rd_q.pos_y} + {{1{py_q[48]}}, py_q[48:16]};
  // the divider takes its operands as it starts, so follow the next selection
  assign fade_x  = sel_alpha_d ? rd_q.look[7:0] : rd_q.look[39:32];
  assign div_num = 28'(fade_x * rd_q.life);

  always_comb begin
    state_d = state_q; act_d = act_q; live_d = live_q; idx_d = idx_q;
    op_d = op_q; dt_d = dt_q; any_d = any_q; sp_d = sp_q; res_d = res_q;
    ov_d = ov_q; wr_en = 1'b0; wr_addr = idx_q[IdxW-1:0]; wr_data = rd_q;
    div_start = 1'b0; sel_alpha_d = sel_alpha_q;
    in_ready = (state_q == S_IDLE) && !ov_q;
    if (ov_q && out_ready) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_valid && in_ready) begin
        op_d = operation_i; dt_d = time_step_i; idx_d = '0; any_d = 1'b0;
        sp_d.pos_x = pos_x_i; sp_d.pos_y = pos_y_i;
        sp_d.vel_x = vel_x_i; sp_d.vel_y = vel_y_i;
        sp_d.life = lifetime_i; sp_d.full_life = lifetime_i;
        sp_d.look = {dot_size_i, red_i, green_i, blue_i, opacity_i};
        res_d = '0; res_d.last = 1'b1;
        if (operation_i == ppu_pkg::OP_TICK) live_d = '0;
        if (operation_i != ppu_pkg::OP_NONE) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (idx_q == CntW'(SlotCount)) begin
          res_d = '0; res_d.last = 1'b1; res_d.live = live_q;
          unique case (op_q)
            ppu_pkg::OP_SPAWN: res_d.kind = ppu_pkg::KIND_DROPPED;
            ppu_pkg::OP_TICK:  res_d.kind = ppu_pkg::KIND_TICKED;
            default:           res_d.kind = any_q ? ppu_pkg::KIND_RECT
                                                  : ppu_pkg::KIND_EMPTY;
          endcase
          if (op_q == ppu_pkg::OP_RENDER && any_q) begin
            // last rectangle was held back to carry the final flag
            res_d = res_q; res_d.last = 1'b1;
          end
          state_d = S_OUT;
        end else if (op_q == ppu_pkg::OP_SPAWN) begin
          if (!act_q[idx_q[IdxW-1:0]]) begin
            wr_en = 1'b1; wr_data = sp_q;
            act_d[idx_q[IdxW-1:0]] = 1'b1;
            live_d = live_q + 7'd1;
            res_d = '0; res_d.kind = ppu_pkg::KIND_SPAWNED;
            res_d.live = live_q + 7'd1; res_d.last = 1'b1;
            state_d = S_OUT;
          end else idx_d = idx_q + 1'b1;
        end else if (act_q[idx_q[IdxW-1:0]]) state_d = S_RD;
        else idx_d = idx_q + 1'b1;
      end
      S_RD: state_d = (op_q == ppu_pkg::OP_TICK) ? S_MUL1 : S_DIV1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_WB;
      S_WB: begin
        wr_en = 1'b1;
        wr_data.pos_x = sat32(nx);
        wr_data.pos_y = sat32(ny);
        wr_data.vel_x = dx_q[47:16];
        wr_data.vel_y = dy_q[47:16];
        if ({4'd0, dt_q} >= rd_q.life) begin
          wr_data.life = '0;
          act_d[idx_q[IdxW-1:0]] = 1'b0;
        end else begin
          wr_data.life = rd_q.life - {4'd0, dt_q};
          live_d = live_q + 7'd1;
        end
        idx_d = idx_q + 1'b1;
        state_d = S_SCAN;
      end
      S_DIV1: begin
        div_start = 1'b1; sel_alpha_d = 1'b0; state_d = S_DIV2;
      end
      S_DIV2: if (div_done) begin
        if (!sel_alpha_q) begin
          sel_alpha_d = 1'b1; div_start = 1'b1;
        end else state_d = S_EMIT;
      end
      S_EMIT: begin
        // emit the held rectangle, keep this one back
        if (!any_q || !ov_q) begin
          ov_d = any_q;
          any_d = 1'b1;
          res_d.kind = ppu_pkg::KIND_RECT; res_d.live = live_q;
          res_d.size = fs_q; res_d.a = fa_q;
          res_d.rx = corner(rd_q.pos_x, fs_q);
          res_d.ry = corner(rd_q.pos_y, fs_q);
          res_d.r = rd_q.look[31:24]; res_d.g = rd_q.look[23:16];
          res_d.b = rd_q.look[15:8]; res_d.last = 1'b0;
          idx_d = idx_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_OUT: if (!ov_q) begin
        ov_d = 1'b1; state_d = S_NEXT;
      end
      S_NEXT: if (!ov_q || out_ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // output register reloads from res whenever it is empty or being taken
  ppu_pkg::res_t shown_q;
  always_ff @(posedge clk_i) begin
    if (!ov_q || out_ready) shown_q <= res_q;
  end

  always_ff @(posedge clk_i) begin
    px_q <= 49'($signed(rd_q.vel_x) * $signed({1'b0, dt_q}));
    py_q <= 49'($signed(rd_q.vel_y) * $signed({1'b0, dt_q}));
    dx_q <= 49'($signed(rd_q.vel_x) * $signed({1'b0, drag_q}));
    dy_q <= 49'($signed(rd_q.vel_y) * $signed({1'b0, drag_q}));
    if (div_done && !sel_alpha_q) fs_q <= div_quot;
    if (div_done && sel_alpha_q) fa_q <= div_quot;
    op_q <= op_d;
    dt_q <= dt_d; sp_q <= sp_d; res_q <= res_d; sel_alpha_q <= sel_alpha_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; act_q <= '0; live_q <= '0; idx_q <= '0;
      any_q <= 1'b0; ov_q <= 1'b0; drag_q <= ppu_pkg::DragReset;
    end else begin
      state_q <= state_d; act_q <= act_d; live_q <= live_d; idx_q <= idx_d;
      any_q <= any_d; ov_q <= ov_d;
      if (cfg_we) drag_q <= cfg_wdata;
    end
  end

  assign out_valid     = ov_q;
  assign result_kind_o = shown_q.kind;
  assign live_total_o  = shown_q.live;
  assign rect_x_o      = shown_q.rx;
  assign rect_y_o      = shown_q.ry;
  assign rect_size_o   = shown_q.size;
  assign out_red_o     = shown_q.r;
  assign out_green_o   = shown_q.g;
  assign out_blue_o    = shown_q.b;
  assign out_alpha_o   = shown_q.a;
  assign last_o        = shown_q.last;
endmodule
